/* hdl/rbsi_pkg.sv */
// Package with the widths, constants and register codes of the ray-box slab test.
package rbsi_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int FRAC_W  = 16;
	localparam int NUM_W   = DIFF_W + FRAC_W;
	localparam int DEN_W   = COORD_W;
	localparam int REM_W   = DEN_W + 1;
	localparam int DIV_LAT = NUM_W + 1;
	localparam int AXES    = 3;
	localparam int OUT_W   = 31;

	localparam logic [DEN_W-1:0] PARALLEL_EPS = 32'd7;

	localparam logic signed [COORD_W-1:0] T_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7fff_ffff;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [2:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [AXES-1:0] par;
		logic            pmiss;
	} side_t;

endpackage

/* hdl/rbsi_ifs.sv */
// Handshake interfaces for the ray words and the result words.
interface rbsi_ray_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rbsi_res_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [30:0] entry_fraction;

	modport source (output valid, hit, entry_fraction, input ready);
	modport sink (input valid, hit, entry_fraction, output ready);
endinterface

/* hdl/rbsi_div.sv */
// Pipelined restoring divider, one quotient bit per stage, signed saturated result.
module rbsi_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rbsi_pkg::NUM_W-1:0] num,
	input  logic [rbsi_pkg::DEN_W-1:0] den,
	input  logic                       neg,
	output rbsi_pkg::coord_t           quot
);
	import rbsi_pkg::*;

	logic [REM_W-2:0] rem_s [1:NUM_W];
	logic [NUM_W-1:0] n_s   [1:NUM_W];
	logic [NUM_W-1:0] q_s   [1:NUM_W];
	logic [DEN_W-1:0] den_s [1:NUM_W];
	logic             neg_s [1:NUM_W];
	coord_t           quot_s;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [REM_W-2:0] rem_in;
		logic [NUM_W-1:0] n_in;
		logic [NUM_W-1:0] q_in;
		logic [DEN_W-1:0] den_in;
		logic             neg_in;
		logic [REM_W-1:0] shifted;
		logic [REM_W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign n_in   = num;
			assign q_in   = '0;
			assign den_in = den;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign n_in   = n_s[k];
			assign q_in   = q_s[k];
			assign den_in = den_s[k];
			assign neg_in = neg_s[k];
		end

		always_comb begin
			shifted = {rem_in, n_in[NUM_W-1]};
			trial   = {1'b0, shifted} - {2'b00, den_in};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= trial[REM_W] ? shifted[REM_W-2:0] : trial[REM_W-2:0];
				n_s[k+1]   <= {n_in[NUM_W-2:0], 1'b0};
				q_s[k+1]   <= {q_in[NUM_W-2:0], ~trial[REM_W]};
				den_s[k+1] <= den_in;
				neg_s[k+1] <= neg_in;
			end
		end
	end

	logic [NUM_W-1:0] q_fin;
	logic             big_pos;
	logic             big_neg;
	logic [DEN_W-1:0] q_neg;

	always_comb begin
		q_fin   = q_s[NUM_W];
		big_pos = (q_fin[NUM_W-1:DEN_W-1] != '0);
		big_neg = (q_fin[NUM_W-1:DEN_W] != '0) || (q_fin[DEN_W-1] && q_fin[DEN_W-2:0] != '0);
		q_neg   = -q_fin[DEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[NUM_W]) begin
				quot_s <= big_neg ? T_MIN : coord_t'(q_neg);
			end else begin
				quot_s <= big_pos ? T_MAX : coord_t'(q_fin[DEN_W-1:0]);
			end
		end
	end

	assign quot = quot_s;

endmodule

/* hdl/ray_box_slab_intersect_unit.sv */
// Top level of the pipelined ray against axis-aligned box slab test.
// One ray word is taken and one result word leaves per cycle; the whole pipeline holds
// when a result waits to be taken. It has one setup stage, the 50 stages of the six
// pipelined slab dividers (one quotient bit per stage over a 49-bit numerator), two
// interval stages and the output register. The user writes box bounds through the
// configuration port only while no word is in flight; the block does not enforce it.
module ray_box_slab_intersect_unit (
	input  logic        clk,
	input  logic        arst_n,
	rbsi_ray_if.sink    ray,
	rbsi_res_if.source  res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rbsi_pkg::*;

	coord_t box_min_q [AXES];
	coord_t box_max_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= 32'sd65536;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en        = !out_valid_q || res.ready;
	assign ray.ready = en;

	coord_t org [AXES];
	coord_t dir [AXES];
	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	logic             v_s1;
	side_t            side_s1;
	logic [NUM_W-1:0] num_lo_s1 [AXES];
	logic [NUM_W-1:0] num_hi_s1 [AXES];
	logic             neg_lo_s1 [AXES];
	logic             neg_hi_s1 [AXES];
	logic [DEN_W-1:0] den_s1    [AXES];

	logic [DEN_W-1:0]         mag   [AXES];
	logic signed [DIFF_W-1:0] d_lo  [AXES];
	logic signed [DIFF_W-1:0] d_hi  [AXES];
	logic [DIFF_W-1:0]        a_lo  [AXES];
	logic [DIFF_W-1:0]        a_hi  [AXES];
	side_t                    side_in;

	always_comb begin
		side_in.pmiss = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			mag[i]  = dir[i][COORD_W-1] ? -dir[i] : dir[i];
			side_in.par[i] = (mag[i] < PARALLEL_EPS);
			d_lo[i] = DIFF_W'(box_min_q[i]) - DIFF_W'(org[i]);
			d_hi[i] = DIFF_W'(box_max_q[i]) - DIFF_W'(org[i]);
			a_lo[i] = d_lo[i][DIFF_W-1] ? -d_lo[i] : d_lo[i];
			a_hi[i] = d_hi[i][DIFF_W-1] ? -d_hi[i] : d_hi[i];
			if (side_in.par[i] && (org[i] < box_min_q[i] || org[i] > box_max_q[i])) begin
				side_in.pmiss = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			for (int i = 0; i < AXES; i++) begin
				num_lo_s1[i] <= {a_lo[i], {FRAC_W{1'b0}}};
				num_hi_s1[i] <= {a_hi[i], {FRAC_W{1'b0}}};
				neg_lo_s1[i] <= d_lo[i][DIFF_W-1] ^ dir[i][COORD_W-1];
				neg_hi_s1[i] <= d_hi[i][DIFF_W-1] ^ dir[i][COORD_W-1];
				den_s1[i]    <= mag[i];
			end
		end
	end

	coord_t t_lo [AXES];
	coord_t t_hi [AXES];

	for (genvar i = 0; i < AXES; i++) begin : g_axis
		rbsi_div u_div_lo (
			.clk  (clk),
			.en   (en),
			.num  (num_lo_s1[i]),
			.den  (den_s1[i]),
			.neg  (neg_lo_s1[i]),
			.quot (t_lo[i])
		);
		rbsi_div u_div_hi (
			.clk  (clk),
			.en   (en),
			.num  (num_hi_s1[i]),
			.den  (den_s1[i]),
			.neg  (neg_hi_s1[i]),
			.quot (t_hi[i])
		);
	end

	logic  dv_s   [1:DIV_LAT];
	side_t side_s [1:DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_LAT; k++) begin
				dv_s[k] <= 1'b0;
			end
		end else if (en) begin
			dv_s[1] <= v_s1;
			for (int k = 2; k <= DIV_LAT; k++) begin
				dv_s[k] <= dv_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_s1;
			for (int k = 2; k <= DIV_LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	logic   v_sa;
	logic   pmiss_sa;
	coord_t lo_sa [AXES];
	coord_t hi_sa [AXES];
	logic   v_sb;
	logic   pmiss_sb;
	coord_t near_sb;
	coord_t far_sb;

	coord_t near_c;
	coord_t far_c;

	always_comb begin
		near_c = lo_sa[0];
		far_c  = hi_sa[0];
		for (int i = 1; i < AXES; i++) begin
			if (lo_sa[i] > near_c) begin
				near_c = lo_sa[i];
			end
			if (hi_sa[i] < far_c) begin
				far_c = hi_sa[i];
			end
		end
	end

	logic        hit_q;
	logic [30:0] frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa        <= 1'b0;
			v_sb        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_sa        <= dv_s[DIV_LAT];
			v_sb        <= v_sa;
			out_valid_q <= v_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pmiss_sa <= side_s[DIV_LAT].pmiss;
			for (int i = 0; i < AXES; i++) begin
				if (side_s[DIV_LAT].par[i]) begin
					lo_sa[i] <= T_MIN;
					hi_sa[i] <= T_MAX;
				end else if (t_lo[i] > t_hi[i]) begin
					lo_sa[i] <= t_hi[i];
					hi_sa[i] <= t_lo[i];
				end else begin
					lo_sa[i] <= t_lo[i];
					hi_sa[i] <= t_hi[i];
				end
			end
			pmiss_sb <= pmiss_sa;
			near_sb  <= near_c;
			far_sb   <= far_c;
			if (pmiss_sb || near_sb > far_sb) begin
				hit_q  <= 1'b0;
				frac_q <= '0;
			end else begin
				hit_q  <= 1'b1;
				frac_q <= near_sb[COORD_W-1] ? '0 : near_sb[OUT_W-1:0];
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.hit            = hit_q;
	assign res.entry_fraction = frac_q;

endmodule
